// File: rtl/pvsd_pkg.sv
// Shared constants and types for the packed vector squared-distance block.
// No dependencies; imported by every module of the block.
package pvsd_pkg;

   localparam int WORD_BITS           = 48;
   localparam int TOTAL_BITS          = 19;
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

   localparam int DEF_LANES           = 8;
   localparam int DEF_COMPONENT_BITS  = 6;
   localparam int DEF_MAX_WORDS       = 12;

   // Control that travels alongside the lane squares.
   typedef struct packed {
      logic valid;
      logic last;
   } pvsd_stage_type;

endpackage

// File: rtl/pvsd_lane.sv
// One lane: extracts its component from both words, takes |a-b| and squares it.
// Depends on pvsd_pkg for the word width.
module pvsd_lane import pvsd_pkg::*; #(
   parameter int COMPONENT_BITS = DEF_COMPONENT_BITS,
   parameter int LANE_INDEX     = 0
) (
   input  logic                        clock,
   input  logic                        load,
   input  logic [WORD_BITS-1:0]        vec_a_word,
   input  logic [WORD_BITS-1:0]        vec_b_word,
   output logic [2*COMPONENT_BITS-1:0] sq_ff
);

   localparam int Base = LANE_INDEX * COMPONENT_BITS;

   logic [COMPONENT_BITS-1:0]   comp_a;
   logic [COMPONENT_BITS-1:0]   comp_b;
   logic [COMPONENT_BITS-1:0]   diff;
   logic [2*COMPONENT_BITS-1:0] sq_in;

   // Bits at or above the top of the word read as zero.
   for (genvar j = 0; j < COMPONENT_BITS; j++) begin : g_bit
      if (Base + j < WORD_BITS) begin : g_in
         assign comp_a[j] = vec_a_word[Base + j];
         assign comp_b[j] = vec_b_word[Base + j];
      end else begin : g_out
         assign comp_a[j] = 1'b0;
         assign comp_b[j] = 1'b0;
      end
   end

   always_comb begin
      diff  = (comp_a >= comp_b) ? (comp_a - comp_b) : (comp_b - comp_a);
      sq_in = (2*COMPONENT_BITS)'(diff) * (2*COMPONENT_BITS)'(diff);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sq_ff <= sq_in;
      end
   end

endmodule

// File: rtl/pvsd_merge.sv
// Merging stage: sums the lane squares, accumulates per vector pair, holds the result.
// Depends on pvsd_pkg for widths, the saturation value and the stage struct.
module pvsd_merge import pvsd_pkg::*; #(
   parameter int LANES          = DEF_LANES,
   parameter int COMPONENT_BITS = DEF_COMPONENT_BITS,
   parameter int MAX_WORDS      = DEF_MAX_WORDS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pvsd_stage_type                         s1,
   input  logic [LANES-1:0][2*COMPONENT_BITS-1:0] lane_sq,
   output logic                                   s2_ready,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [TOTAL_BITS-1:0]                  rsp_distance,
   output logic                                   rsp_overflow
);

   localparam int SumBits   = 2*COMPONENT_BITS + $clog2(LANES + 1);
   localparam int AccBits   = ((SumBits > TOTAL_BITS) ? SumBits : TOTAL_BITS) + 1;
   localparam int CountBits = $clog2(MAX_WORDS + 1);

   logic                  s2_valid_ff, s2_valid_in;
   logic                  s2_last_ff;
   logic [SumBits-1:0]    s2_sum_ff, lane_sum;
   logic                  s2_load, acc_take;

   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic [CountBits-1:0]  count_ff, count_in;
   logic                  sat_ff, sat_in;
   logic [AccBits-1:0]    acc_sum;
   logic [TOTAL_BITS-1:0] step_total;
   logic [CountBits-1:0]  step_count;
   logic                  step_sat;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_BITS-1:0] rsp_distance_ff;
   logic                  rsp_overflow_ff;

   always_comb begin
      lane_sum = '0;
      for (int i = 0; i < LANES; i++) begin
         lane_sum = lane_sum + SumBits'(lane_sq[i]);
      end
   end

   // A non-last word never needs the result register; a last one waits for it.
   assign acc_take    = s2_valid_ff && (!s2_last_ff || !rsp_valid_ff || rsp_ready);
   assign s2_ready    = !s2_valid_ff || acc_take;
   assign s2_load     = s1.valid && s2_ready;
   assign s2_valid_in = s2_ready ? s1.valid : s2_valid_ff;

   always_comb begin
      acc_sum    = AccBits'(total_ff) + AccBits'(s2_sum_ff);
      step_total = total_ff;
      step_count = count_ff;
      step_sat   = sat_ff;
      if (count_ff >= CountBits'(MAX_WORDS)) begin
         step_sat   = 1'b1;
         step_total = TOTAL_MAX;
      end else begin
         if (acc_sum > AccBits'(TOTAL_MAX)) begin
            step_total = TOTAL_MAX;
            step_sat   = 1'b1;
         end else begin
            step_total = acc_sum[TOTAL_BITS-1:0];
         end
         step_count = count_ff + CountBits'(1);
      end

      total_in = total_ff;
      count_in = count_ff;
      sat_in   = sat_ff;
      if (acc_take) begin
         if (s2_last_ff) begin
            total_in = '0;
            count_in = '0;
            sat_in   = 1'b0;
         end else begin
            total_in = step_total;
            count_in = step_count;
            sat_in   = step_sat;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (acc_take && s2_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         total_ff     <= '0;
         count_ff     <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_sum_ff  <= lane_sum;
         s2_last_ff <= s1.last;
      end
      if (acc_take && s2_last_ff) begin
         rsp_distance_ff <= step_total;
         rsp_overflow_ff <= step_sat;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_overflow = rsp_overflow_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountBits'(MAX_WORDS))
      else $error("word count beyond its limit");

   a_sat_total: assert property (@(posedge clock) disable iff (reset)
      sat_ff |-> total_ff == TOTAL_MAX)
      else $error("saturated without a saturated total");

   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      acc_take && s2_last_ff |=> count_ff == '0 && total_ff == '0 && !sat_ff)
      else $error("state not cleared after last word");

   a_overflow_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_overflow_ff |-> rsp_distance_ff == TOTAL_MAX)
      else $error("overflow result without saturated distance");

   a_no_lost_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !(acc_take && s2_last_ff))
      else $error("held result overwritten");

endmodule

// File: rtl/packed_vector_sq_distance.sv
// Top level of the packed vector squared-distance block.
// Depends on pvsd_pkg, pvsd_lane and pvsd_merge.
//
// Usage:
//   req_ channel carries one word pair per transfer: LANES components of
//   COMPONENT_BITS bits each, lane i at bit i*COMPONENT_BITS, plus
//   req_last_word on the final pair of the two vectors.
//   rsp_ channel carries one result per vector pair: the squared distance and
//   an overflow flag, raised when more than MAX_WORDS pairs arrived or the
//   total passed the 19-bit range (the distance then reads all ones).
//   Throughput is one word pair per cycle while req_ready is high. Pipeline:
//   lane squares, lane sum, then the accumulator feeding the result register;
//   a last word passes the lane and sum registers before its result is valid.
//   When rsp_ready is low the held result stays, non-last words keep
//   accumulating, and a further last word waits in the pipeline; req_ready
//   drops only once every stage is full.
//   Synchronous reset empties the pipeline and clears the running total,
//   word count and overflow flag.
module packed_vector_sq_distance import pvsd_pkg::*; #(
   parameter int LANES          = DEF_LANES,
   parameter int COMPONENT_BITS = DEF_COMPONENT_BITS,
   parameter int MAX_WORDS      = DEF_MAX_WORDS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [WORD_BITS-1:0]  req_vec_a_word,
   input  logic [WORD_BITS-1:0]  req_vec_b_word,
   input  logic                  req_last_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [TOTAL_BITS-1:0] rsp_distance,
   output logic                  rsp_overflow
);

   logic                                   s1_valid_ff, s1_valid_in;
   logic                                   s1_last_ff;
   logic                                   s2_ready;
   logic                                   req_take;
   logic [LANES-1:0][2*COMPONENT_BITS-1:0] lane_sq;
   pvsd_stage_type                         s1;

   assign req_ready   = !s1_valid_ff || s2_ready;
   assign req_take    = req_valid && req_ready;
   assign s1_valid_in = req_take ? 1'b1 : (s2_ready ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_last_ff <= req_last_word;
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      pvsd_lane #(
         .COMPONENT_BITS (COMPONENT_BITS),
         .LANE_INDEX     (i)
      ) u_lane (
         .clock      (clock),
         .load       (req_take),
         .vec_a_word (req_vec_a_word),
         .vec_b_word (req_vec_b_word),
         .sq_ff      (lane_sq[i])
      );
   end

   assign s1.valid = s1_valid_ff;
   assign s1.last  = s1_last_ff;

   pvsd_merge #(
      .LANES          (LANES),
      .COMPONENT_BITS (COMPONENT_BITS),
      .MAX_WORDS      (MAX_WORDS)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .s1           (s1),
      .lane_sq      (lane_sq),
      .s2_ready     (s2_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_distance (rsp_distance),
      .rsp_overflow (rsp_overflow)
   );

endmodule

// File: test/packed_vector_sq_distance_tb.sv
// Self-checking testbench for packed_vector_sq_distance: streams word pairs with random gaps
// and result stalls, predicts each squared distance and compares every result transfer.
// Depends on pvsd_pkg and the packed_vector_sq_distance RTL.
module packed_vector_sq_distance_tb import pvsd_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LANE_COUNT     = DEF_LANES;
   localparam int LANE_BITS      = DEF_COMPONENT_BITS;
   localparam int MAX_WORD_COUNT = DEF_MAX_WORDS;
   localparam int WORD_TARGET    = 1700;
   localparam int CYCLE_LIMIT    = 500000;
   localparam int DRAIN_CYCLES   = 10;

   typedef struct packed {
      logic [TOTAL_BITS-1:0] distance;
      logic                  overflow;
   } distance_result_type;

   class distance_scoreboard;
      logic [TOTAL_BITS-1:0] total;
      logic [4:0]            words_seen;
      logic                  saturated;
      distance_result_type   expected_q[$];
      int                    errors;

      function new();
         total      = '0;
         words_seen = '0;
         saturated  = 1'b0;
         errors     = 0;
      endfunction

      function int unsigned pair_square_sum(logic [WORD_BITS-1:0] a, logic [WORD_BITS-1:0] b);
         int unsigned acc;
         int unsigned da;
         int unsigned db;
         int unsigned diff;
         acc = 0;
         for (int i = 0; i < LANE_COUNT; i++) begin
            da   = 32'(a[i*LANE_BITS +: LANE_BITS]);
            db   = 32'(b[i*LANE_BITS +: LANE_BITS]);
            diff = (da >= db) ? da - db : db - da;
            acc += diff * diff;
         end
         return acc;
      endfunction

      function void note_word(logic [WORD_BITS-1:0] a, logic [WORD_BITS-1:0] b, logic last);
         int unsigned         next_total;
         distance_result_type res;
         if (words_seen >= MAX_WORD_COUNT) begin
            // vector too long: pin the total at all ones
            saturated = 1'b1;
            total     = TOTAL_MAX;
         end else begin
            next_total = 32'(total) + pair_square_sum(a, b);
            if (next_total > 32'(TOTAL_MAX)) begin
               next_total = 32'(TOTAL_MAX);
               saturated  = 1'b1;
            end
            total      = next_total[TOTAL_BITS-1:0];
            words_seen = words_seen + 5'd1;
         end
         if (last) begin
            res.distance = total;
            res.overflow = saturated;
            expected_q.push_back(res);
            total      = '0;
            words_seen = '0;
            saturated  = 1'b0;
         end
      endfunction

      function void check_result(logic [TOTAL_BITS-1:0] distance, logic overflow);
         distance_result_type exp_res;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result distance=%0d overflow=%0b", $realtime,
                     distance, overflow);
            errors++;
            return;
         end
         exp_res = expected_q.pop_front();
         if (distance !== exp_res.distance) begin
            $display("%0t: distance mismatch: expected %0d, actual %0d", $realtime,
                     exp_res.distance, distance);
            errors++;
         end
         if (overflow !== exp_res.overflow) begin
            $display("%0t: overflow mismatch: expected %0b, actual %0b", $realtime,
                     exp_res.overflow, overflow);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [WORD_BITS-1:0]  req_vec_a_word = '0;
   logic [WORD_BITS-1:0]  req_vec_b_word = '0;
   logic                  req_last_word = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [TOTAL_BITS-1:0] rsp_distance;
   logic                  rsp_overflow;

   distance_scoreboard sb = new();
   bit                 steady = 1'b0;
   int                 words_sent = 0;
   int                 cycles = 0;

   packed_vector_sq_distance uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_vec_a_word (req_vec_a_word),
      .req_vec_b_word (req_vec_b_word),
      .req_last_word  (req_last_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_distance   (rsp_distance),
      .rsp_overflow   (rsp_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
   end

   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // Sample both channels with pre-edge values; results first, they never
   // belong to a word taken at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_distance, rsp_overflow);
         end
         if (req_valid && req_ready) begin
            sb.note_word(req_vec_a_word, req_vec_b_word, req_last_word);
         end
      end
   end

   function automatic int draw_wait();
      return steady ? 0 : $urandom_range(0, 19);
   endfunction

   function automatic logic [WORD_BITS-1:0] random_word();
      logic [WORD_BITS-1:0] w;
      int unsigned          pick;
      w[31:0]  = $urandom;
      w[47:32] = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 2) == 0) begin
         // bias lanes towards the component extremes
         for (int i = 0; i < LANE_COUNT; i++) begin
            pick = $urandom_range(0, 3);
            if (pick == 0) begin
               w[i*LANE_BITS +: LANE_BITS] = '0;
            end else if (pick == 1) begin
               w[i*LANE_BITS +: LANE_BITS] = '1;
            end
         end
      end
      return w;
   endfunction

   // Leaves the caller at the edge of the transfer.
   task automatic send_word(logic [WORD_BITS-1:0] a, logic [WORD_BITS-1:0] b, logic last);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_vec_a_word <= a;
      req_vec_b_word <= b;
      req_last_word  <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_vector(int unsigned len);
      for (int unsigned i = 1; i <= len; i++) begin
         send_word(random_word(), random_word(), i == len);
      end
   endtask

   // Hold off the sender until every outstanding distance has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int stall;
      wait (!reset);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      logic [WORD_BITS-1:0] w;
      int unsigned          len;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // full-scale difference on every lane, then mixed directions per lane
      send_word('1, '0, 1'b1);
      send_word(48'h03F03F03F03F, 48'hFC0FC0FC0FC0, 1'b1);
      w = random_word();
      send_word(w, w, 1'b1);
      // longest legal vector at full scale: largest distance without overflow
      steady = 1'b1;
      for (int i = 1; i <= MAX_WORD_COUNT; i++) begin
         send_word('0, '1, i == MAX_WORD_COUNT);
      end
      steady = 1'b0;
      // one word too many: the total saturates
      for (int i = 1; i <= MAX_WORD_COUNT + 1; i++) begin
         send_word(random_word(), random_word(), i == MAX_WORD_COUNT + 1);
      end
      drain_results();

      while (words_sent < WORD_TARGET) begin
         if ($urandom_range(0, 11) == 0) begin
            steady = !steady;
         end
         case ($urandom_range(0, 9))
            0:       len = $urandom_range(MAX_WORD_COUNT + 1, MAX_WORD_COUNT + 8);
            1:       len = MAX_WORD_COUNT;
            2:       len = 1;
            default: len = $urandom_range(1, MAX_WORD_COUNT);
         endcase
         send_vector(len);
         if ($urandom_range(0, 39) == 0) begin
            drain_results();
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/pvsd_pkg.sv
rtl/pvsd_lane.sv
rtl/pvsd_merge.sv
rtl/packed_vector_sq_distance.sv
test/packed_vector_sq_distance_tb.sv
